@@ rtl/oxygen_valve_stepper_control_top_defines.svh @@
// ----------------------------------------------------------------------------
// oxygen valve stepper control: assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef OXYGEN_VALVE_STEPPER_CONTROL_TOP_DEFINES_SVH
`define OXYGEN_VALVE_STEPPER_CONTROL_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define OVSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ovsc same-cycle check failed");

// next-cycle implication, masked during reset
`define OVSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ovsc next-cycle check failed");

`endif

@@ rtl/ovsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ovsc_pkg
// types and constants shared by the oxygen valve stepper control block
// ----------------------------------------------------------------------------
package ovsc_pkg;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_READING   = 2'd1,
        CMD_LINK_UP   = 2'd2,
        CMD_LINK_DOWN = 2'd3
    } t_cmd;

    // configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_CHUNK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALVE_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_TARGET_LEVEL  = 8'd98;
    localparam logic [9:0]  RST_MOVE_CHUNK    = 10'd50;
    localparam logic [9:0]  RST_VALVE_LIMIT   = 10'd500;
    localparam logic [15:0] RST_HALF_PERIOD   = 16'd800;
    localparam logic [31:0] RST_SILENCE_LIMIT = 32'd30000000;

    // shortest reading packet that carries spo2 and heart rate
    localparam logic [7:0] MIN_PACKET_LEN = 8'd5;

    // fixed field widths
    localparam int VALVE_W = 10;
    localparam int PHASE_W = 16;

    typedef struct packed {
        logic [7:0]  target_level;
        logic [9:0]  move_chunk;
        logic [9:0]  valve_limit;
        logic [15:0] half_period;
        logic [31:0] silence_limit;
    } t_cfg;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  packet_length;
        logic [7:0]  spo2;
        logic [7:0]  heart_rate;
    } t_cmd_item;

    typedef struct packed {
        logic               step_out;
        logic               dir_out;
        logic               alarm_out;
        logic [VALVE_W-1:0] valve_steps;
        logic               moving;
        logic               reading_dropped;
        logic [7:0]         last_spo2;
        logic [7:0]         last_pulse;
    } t_result;

endpackage

@@ rtl/ovsc_channels.sv @@
// ----------------------------------------------------------------------------
// ovsc channels
// valid/ready interfaces for the command and result streams
// ----------------------------------------------------------------------------

// command stream
interface ovsc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] packet_length;
    logic [7:0] spo2;
    logic [7:0] heart_rate;

    modport source (output valid, output command, output packet_length,
                    output spo2, output heart_rate, input ready);
    modport sink   (input valid, input command, input packet_length,
                    input spo2, input heart_rate, output ready);
endinterface

// result stream
interface ovsc_res_if;
    logic       valid;
    logic       ready;
    logic       step_out;
    logic       dir_out;
    logic       alarm_out;
    logic [9:0] valve_steps;
    logic       moving;
    logic       reading_dropped;
    logic [7:0] last_spo2;
    logic [7:0] last_pulse;

    modport source (output valid, output step_out, output dir_out, output alarm_out,
                    output valve_steps, output moving, output reading_dropped,
                    output last_spo2, output last_pulse, input ready);
    modport sink   (input valid, input step_out, input dir_out, input alarm_out,
                    input valve_steps, input moving, input reading_dropped,
                    input last_spo2, input last_pulse, output ready);
endinterface

@@ rtl/ovsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ovsc_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module ovsc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ovsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ovsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ovsc_pkg::t_cfg                    o_cfg
);

    ovsc_pkg::t_cfg r_cfg;

    // register writes, unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_level  <= ovsc_pkg::RST_TARGET_LEVEL;
            r_cfg.move_chunk    <= ovsc_pkg::RST_MOVE_CHUNK;
            r_cfg.valve_limit   <= ovsc_pkg::RST_VALVE_LIMIT;
            r_cfg.half_period   <= ovsc_pkg::RST_HALF_PERIOD;
            r_cfg.silence_limit <= ovsc_pkg::RST_SILENCE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ovsc_pkg::REG_TARGET_LEVEL:  r_cfg.target_level  <= i_cfg_data[7:0];
                ovsc_pkg::REG_MOVE_CHUNK:    r_cfg.move_chunk    <= i_cfg_data[9:0];
                ovsc_pkg::REG_VALVE_LIMIT:   r_cfg.valve_limit   <= i_cfg_data[9:0];
                ovsc_pkg::REG_HALF_PERIOD:   r_cfg.half_period   <= i_cfg_data[15:0];
                ovsc_pkg::REG_SILENCE_LIMIT: r_cfg.silence_limit <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/ovsc_core.sv @@
// ----------------------------------------------------------------------------
// ovsc_core
// controller state and its single-pass update for one command transaction
// ----------------------------------------------------------------------------
module ovsc_core #(
    parameter int POSITION_BITS = 10,
    parameter int TIMER_BITS    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  ovsc_pkg::t_cfg       i_cfg,
    input  ovsc_pkg::t_cmd_item  i_item,
    output ovsc_pkg::t_result    o_result
);

    localparam int PB = POSITION_BITS;
    localparam int TB = TIMER_BITS;
    // compare widths for mixed-width limits
    localparam int CW = (PB > 10) ? PB : 10;
    localparam int SW = (TB > 32) ? TB : 32;
    localparam logic [CW-1:0] POS_MAX_C = CW'((64'd1 << PB) - 64'd1);

    logic [PB-1:0]                  r_position, n_position;
    logic [PB-1:0]                  r_pending,  n_pending;
    logic                           r_direction, n_direction;
    logic                           r_step_level, n_step_level;
    logic [ovsc_pkg::PHASE_W-1:0]   r_phase,    n_phase;
    logic [TB-1:0]                  r_silence,  n_silence;
    logic                           r_linked,   n_linked;
    logic                           r_alarm,    n_alarm;
    logic [7:0]                     r_spo2,     n_spo2;
    logic [7:0]                     r_pulse,    n_pulse;
    logic                           dropped;

    logic [CW-1:0]                  lim_c;
    logic [CW-1:0]                  chunk_c;
    logic [PB-1:0]                  limit;
    logic [PB-1:0]                  room;
    logic [PB-1:0]                  steps_open;
    logic [PB-1:0]                  steps_close;
    logic [TB-1:0]                  sil_inc;
    logic [ovsc_pkg::PHASE_W-1:0]   phase_inc;

    // move planning: valve limit clamped to the position range
    always_comb begin
        lim_c       = (CW'(i_cfg.valve_limit) > POS_MAX_C) ? POS_MAX_C
                                                           : CW'(i_cfg.valve_limit);
        limit       = lim_c[PB-1:0];
        chunk_c     = CW'(i_cfg.move_chunk);
        room        = (limit > r_position) ? (limit - r_position) : '0;
        steps_open  = (chunk_c < CW'(room)) ? chunk_c[PB-1:0] : room;
        steps_close = (chunk_c < CW'(r_position)) ? chunk_c[PB-1:0] : r_position;
    end

    // saturating silence timer and phase counter increments
    assign sil_inc   = (r_silence != {TB{1'b1}}) ? (r_silence + TB'(1)) : r_silence;
    assign phase_inc = r_phase + ovsc_pkg::PHASE_W'(1);

    // next state for the command
    always_comb begin
        n_position   = r_position;
        n_pending    = r_pending;
        n_direction  = r_direction;
        n_step_level = r_step_level;
        n_phase      = r_phase;
        n_silence    = r_silence;
        n_linked     = r_linked;
        n_alarm      = r_alarm;
        n_spo2       = r_spo2;
        n_pulse      = r_pulse;
        dropped      = 1'b0;

        unique case (i_item.command)
            ovsc_pkg::CMD_TICK: begin
                n_silence = sil_inc;
                if (r_linked && (SW'(sil_inc) > SW'(i_cfg.silence_limit))) begin
                    n_alarm = 1'b1;
                end
                // step pulse generation, a falling edge completes a step
                if (r_pending != '0) begin
                    if (phase_inc >= i_cfg.half_period) begin
                        n_phase = '0;
                        if (r_step_level) begin
                            n_step_level = 1'b0;
                            n_pending    = r_pending - PB'(1);
                        end else begin
                            n_step_level = 1'b1;
                        end
                    end else begin
                        n_phase = phase_inc;
                    end
                end
            end
            ovsc_pkg::CMD_READING: begin
                if (i_item.packet_length >= ovsc_pkg::MIN_PACKET_LEN) begin
                    if (r_pending != '0) begin
                        dropped = 1'b1;
                    end else begin
                        n_spo2    = i_item.spo2;
                        n_pulse   = i_item.heart_rate;
                        n_silence = '0;
                        n_alarm   = 1'b0;
                        // open below target, close above, hold when equal
                        if (i_item.spo2 < i_cfg.target_level) begin
                            if (steps_open != '0) begin
                                n_direction  = 1'b1;
                                n_position   = r_position + steps_open;
                                n_pending    = steps_open;
                                n_step_level = 1'b1;
                                n_phase      = '0;
                            end
                        end else if (i_item.spo2 > i_cfg.target_level) begin
                            if (steps_close != '0) begin
                                n_direction  = 1'b0;
                                n_position   = r_position - steps_close;
                                n_pending    = steps_close;
                                n_step_level = 1'b1;
                                n_phase      = '0;
                            end
                        end
                    end
                end
            end
            ovsc_pkg::CMD_LINK_UP: begin
                n_linked  = 1'b1;
                n_silence = '0;
                n_alarm   = 1'b0;
            end
            ovsc_pkg::CMD_LINK_DOWN: begin
                n_linked = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // state registers, updated once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_pending    <= '0;
            r_direction  <= 1'b0;
            r_step_level <= 1'b0;
            r_phase      <= '0;
            r_silence    <= '0;
            r_linked     <= 1'b0;
            r_alarm      <= 1'b0;
            r_spo2       <= '0;
            r_pulse      <= '0;
        end else if (i_en) begin
            r_position   <= n_position;
            r_pending    <= n_pending;
            r_direction  <= n_direction;
            r_step_level <= n_step_level;
            r_phase      <= n_phase;
            r_silence    <= n_silence;
            r_linked     <= n_linked;
            r_alarm      <= n_alarm;
            r_spo2       <= n_spo2;
            r_pulse      <= n_pulse;
        end
    end

    // result of the transaction, taken from the updated state
    always_comb begin
        o_result.step_out        = n_step_level;
        o_result.dir_out         = n_direction;
        o_result.alarm_out       = n_alarm;
        o_result.valve_steps     = ovsc_pkg::VALVE_W'(n_position);
        o_result.moving          = (n_pending != '0);
        o_result.reading_dropped = dropped;
        o_result.last_spo2       = n_spo2;
        o_result.last_pulse      = n_pulse;
    end

endmodule

@@ rtl/oxygen_valve_stepper_control_top.sv @@
// ----------------------------------------------------------------------------
// oxygen_valve_stepper_control_top
// oximeter-driven valve stepper controller with silence alarm
//
//   channel   direction  contents
//   i_cmd     in         command, packet_length, spo2, heart_rate
//   o_res     out        step and direction levels, alarm, valve state, last values
//   i_cfg_*   in         register writes: enable, index, data
//
// one transaction per cycle sustained while the result side keeps up; a result is presented
// after its command passes the input register, then the result register
// the state update is one pass of logic between the two registers
// synchronous active-low reset clears the valid flags and controller state and restores register defaults
// a stalled result holds while the input register still takes one more command
// ----------------------------------------------------------------------------
module oxygen_valve_stepper_control_top #(
    parameter int POSITION_BITS = 10,
    parameter int TIMER_BITS    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ovsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ovsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ovsc_cmd_if.sink                        i_cmd,
    ovsc_res_if.source                      o_res
);

    ovsc_pkg::t_cfg      cfg;
    ovsc_pkg::t_cmd_item r_item;
    logic                r_item_valid;
    ovsc_pkg::t_result   core_result;
    ovsc_pkg::t_result   r_res;
    logic                r_res_valid;
    logic                advance;

    // the command in the input register moves on when the result slot frees up
    assign advance     = r_item_valid && (!r_res_valid || o_res.ready);
    assign i_cmd.ready = !r_item_valid || advance;

    ovsc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_item_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_item.command       <= ovsc_pkg::t_cmd'(i_cmd.command);
            r_item.packet_length <= i_cmd.packet_length;
            r_item.spo2          <= i_cmd.spo2;
            r_item.heart_rate    <= i_cmd.heart_rate;
        end
    end

    ovsc_core #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (!r_res_valid || o_res.ready) begin
            r_res_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_result;
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.step_out        = r_res.step_out;
    assign o_res.dir_out         = r_res.dir_out;
    assign o_res.alarm_out       = r_res.alarm_out;
    assign o_res.valve_steps     = r_res.valve_steps;
    assign o_res.moving          = r_res.moving;
    assign o_res.reading_dropped = r_res.reading_dropped;
    assign o_res.last_spo2       = r_res.last_spo2;
    assign o_res.last_pulse      = r_res.last_pulse;

endmodule

@@ rtl/ovsc_checker.sv @@
// ----------------------------------------------------------------------------
// ovsc_checker
// port-level checks on the controller, bound to the top level
// ----------------------------------------------------------------------------
`include "oxygen_valve_stepper_control_top_defines.svh"

module ovsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cmd_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_step_out,
    input logic       i_dir_out,
    input logic       i_alarm_out,
    input logic [9:0] i_valve_steps,
    input logic       i_moving,
    input logic       i_reading_dropped,
    input logic [7:0] i_last_spo2,
    input logic [7:0] i_last_pulse
);

    // a stalled result transaction holds its contents
    `OVSC_ASSERT_NEXT(a_res_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_step_out) && $stable(i_dir_out) && $stable(i_alarm_out) && $stable(i_valve_steps) && $stable(i_moving) && $stable(i_reading_dropped) && $stable(i_last_spo2) && $stable(i_last_pulse))

    // a free result side never blocks the command side
    `OVSC_ASSERT_IMPLY(a_cmd_flow, i_clk, i_rst_n, i_res_ready, i_cmd_ready)

    // a reading is only dropped while a move is under way
    `OVSC_ASSERT_IMPLY(a_drop_moving, i_clk, i_rst_n, i_res_valid && i_reading_dropped, i_moving)

    // the step line is only high while steps remain
    `OVSC_ASSERT_IMPLY(a_step_moving, i_clk, i_rst_n, i_res_valid && i_step_out, i_moving)

endmodule

bind oxygen_valve_stepper_control_top ovsc_checker u_ovsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_step_out        (o_res.step_out),
    .i_dir_out         (o_res.dir_out),
    .i_alarm_out       (o_res.alarm_out),
    .i_valve_steps     (o_res.valve_steps),
    .i_moving          (o_res.moving),
    .i_reading_dropped (o_res.reading_dropped),
    .i_last_spo2       (o_res.last_spo2),
    .i_last_pulse      (o_res.last_pulse)
);

@@ dv/oxygen_valve_stepper_control_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oxygen_valve_stepper_control_top_test
// self-checking bench for the valve stepper controller: command transactions
// with random gaps and a long result stall, every result compared field by
// field with an in-bench prediction of valve position, step timing and alarm
// ----------------------------------------------------------------------------
module oxygen_valve_stepper_control_top_test;
    import ovsc_pkg::*;

    localparam int IDLE_PCT        = 36;
    localparam int SETTLE_CYCLES   = 4;
    localparam int FULL_RATE_FROM  = 700;
    localparam int FULL_RATE_TO    = 900;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 120;
    localparam int MAX_PRINTED     = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ovsc_cmd_if cmd_if ();
    ovsc_res_if res_if ();

    oxygen_valve_stepper_control_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    // stimulus and expectation stores
    t_cmd_item   commands_pending[$];
    t_result     valve_results_due[$];
    t_cmd_item   offered;
    int unsigned n_sent    = 0;
    int unsigned n_taken   = 0;
    int unsigned n_results = 0;
    int unsigned errors    = 0;
    logic        hold_results = 1'b0;

    // coverage tallies
    int unsigned n_settings = 0;
    int unsigned n_moves    = 0;
    int unsigned n_steps    = 0;
    int unsigned n_dropped  = 0;
    int unsigned n_alarms   = 0;

    // predicted controller state
    t_cfg               cfg_shadow;
    logic [VALVE_W-1:0] pos_q;
    logic [VALVE_W-1:0] pend_q;
    logic [PHASE_W-1:0] phase_q;
    logic [31:0]        silence_q;
    logic               dir_q;
    logic               level_q;
    logic               linked_q;
    logic               alarm_q;
    logic [7:0]         spo2_q;
    logic [7:0]         pulse_q;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < MAX_PRINTED)
            $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
                     $time, what, n_results, got, want);
        errors++;
    endtask

    // one command in, one predicted controller snapshot out
    task automatic predict_valve_result(input t_cmd_item it);
        t_result            r;
        logic [VALVE_W-1:0] room;
        logic [VALVE_W-1:0] steps;
        logic               dropped;
        dropped = 1'b0;
        case (it.command)
            CMD_TICK: begin
                if (silence_q != '1) silence_q = silence_q + 1'b1;
                if (linked_q && silence_q > cfg_shadow.silence_limit) begin
                    if (!alarm_q) n_alarms++;
                    alarm_q = 1'b1;
                end
                // step pulse timing, zero half period acts as one
                if (pend_q != '0) begin
                    phase_q = phase_q + 1'b1;
                    if (phase_q >= cfg_shadow.half_period) begin
                        phase_q = '0;
                        if (level_q) begin
                            level_q = 1'b0;
                            pend_q  = pend_q - 1'b1;
                            n_steps++;
                        end else begin
                            level_q = 1'b1;
                        end
                    end
                end
            end
            CMD_READING: begin
                if (it.packet_length >= MIN_PACKET_LEN) begin
                    if (pend_q != '0) begin
                        dropped = 1'b1;
                        n_dropped++;
                    end else begin
                        spo2_q    = it.spo2;
                        pulse_q   = it.heart_rate;
                        silence_q = '0;
                        alarm_q   = 1'b0;
                        // plan the move, bounded by chunk and by valve range
                        steps = '0;
                        if (spo2_q < cfg_shadow.target_level) begin
                            room  = (cfg_shadow.valve_limit > pos_q) ?
                                    cfg_shadow.valve_limit - pos_q : '0;
                            steps = (cfg_shadow.move_chunk < room) ?
                                    cfg_shadow.move_chunk : room;
                        end else if (spo2_q > cfg_shadow.target_level) begin
                            steps = (cfg_shadow.move_chunk < pos_q) ?
                                    cfg_shadow.move_chunk : pos_q;
                        end
                        if (steps != '0) begin
                            dir_q   = (spo2_q < cfg_shadow.target_level);
                            pos_q   = dir_q ? pos_q + steps : pos_q - steps;
                            pend_q  = steps;
                            level_q = 1'b1;
                            phase_q = '0;
                            n_moves++;
                        end
                    end
                end
            end
            CMD_LINK_UP: begin
                linked_q  = 1'b1;
                silence_q = '0;
                alarm_q   = 1'b0;
            end
            default: begin
                linked_q = 1'b0;
            end
        endcase
        r.step_out        = level_q;
        r.dir_out         = dir_q;
        r.alarm_out       = alarm_q;
        r.valve_steps     = pos_q;
        r.moving          = (pend_q != '0);
        r.reading_dropped = dropped;
        r.last_spo2       = spo2_q;
        r.last_pulse      = pulse_q;
        valve_results_due.push_back(r);
    endtask

    task automatic check_valve_result();
        t_result want;
        if (valve_results_due.size() == 0) begin
            report_mismatch("unexpected result", res_if.valve_steps, 0);
        end else begin
            want = valve_results_due.pop_front();
            if (res_if.step_out !== want.step_out)
                report_mismatch("step_out", res_if.step_out, want.step_out);
            if (res_if.dir_out !== want.dir_out)
                report_mismatch("dir_out", res_if.dir_out, want.dir_out);
            if (res_if.alarm_out !== want.alarm_out)
                report_mismatch("alarm_out", res_if.alarm_out, want.alarm_out);
            if (res_if.valve_steps !== want.valve_steps)
                report_mismatch("valve_steps", res_if.valve_steps, want.valve_steps);
            if (res_if.moving !== want.moving)
                report_mismatch("moving", res_if.moving, want.moving);
            if (res_if.reading_dropped !== want.reading_dropped)
                report_mismatch("reading_dropped", res_if.reading_dropped,
                                want.reading_dropped);
            if (res_if.last_spo2 !== want.last_spo2)
                report_mismatch("last_spo2", res_if.last_spo2, want.last_spo2);
            if (res_if.last_pulse !== want.last_pulse)
                report_mismatch("last_pulse", res_if.last_pulse, want.last_pulse);
        end
        n_results++;
    endtask

    function automatic logic full_rate();
        return (n_taken >= FULL_RATE_FROM) && (n_taken < FULL_RATE_TO);
    endfunction

    // command driver: holds a transaction until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                predict_valve_result(offered);
                n_taken++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (commands_pending.size() != 0 &&
                    (full_rate() || $urandom_range(99) >= IDLE_PCT)) begin
                    offered = commands_pending.pop_front();
                    cmd_if.valid         <= 1'b1;
                    cmd_if.command       <= offered.command;
                    cmd_if.packet_length <= offered.packet_length;
                    cmd_if.spo2          <= offered.spo2;
                    cmd_if.heart_rate    <= offered.heart_rate;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_valve_result();
            res_if.ready <= !hold_results &&
                            (full_rate() || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // one long result stall so the block fills and blocks its input
    initial begin : result_backpressure
        int unsigned held;
        wait (n_taken >= PRESSURE_AT);
        @(posedge i_clk);
        hold_results <= 1'b1;
        for (held = 0; held < PRESSURE_CYCLES; held++) @(posedge i_clk);
        hold_results <= 1'b0;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("[%0t] timeout with %0d transactions sent, %0d taken, %0d results",
                 $time, n_sent, n_taken, n_results);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic wait_until_drained();
        while (commands_pending.size() != 0 || n_taken != n_sent ||
               valve_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // register writes, only with nothing in flight
    task automatic write_settings(input t_cfg c);
        int                    r;
        logic [CFG_DATA_W-1:0] value;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (r = REG_TARGET_LEVEL; r <= REG_SILENCE_LIMIT; r++) begin
            case (r)
                REG_TARGET_LEVEL: value = CFG_DATA_W'(c.target_level);
                REG_MOVE_CHUNK:   value = CFG_DATA_W'(c.move_chunk);
                REG_VALVE_LIMIT:  value = CFG_DATA_W'(c.valve_limit);
                REG_HALF_PERIOD:  value = CFG_DATA_W'(c.half_period);
                default:          value = CFG_DATA_W'(c.silence_limit);
            endcase
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(r);
            i_cfg_data <= value;
        end
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_shadow = c;
        n_settings++;
    endtask

    task automatic queue_command(input t_cmd cmd, input int len, input int spo2,
                                 input int hr);
        t_cmd_item it;
        it.command       = cmd;
        it.packet_length = 8'(len);
        it.spo2          = 8'(spo2);
        it.heart_rate    = 8'(hr);
        commands_pending.push_back(it);
        n_sent++;
    endtask

    // mostly ticks so moves play out, readings clustered around the target
    function automatic t_cmd_item random_command(input int unsigned tick_pct,
                                                 input logic [7:0] target);
        t_cmd_item   it;
        int unsigned roll;
        roll             = $urandom_range(99);
        it.packet_length = 8'($urandom_range(255));
        it.spo2          = 8'($urandom_range(255));
        it.heart_rate    = 8'($urandom_range(255));
        if (roll < tick_pct) begin
            it.command = CMD_TICK;
        end else if (roll < tick_pct + 5) begin
            it.command = CMD_LINK_UP;
        end else if (roll < tick_pct + 9) begin
            it.command = CMD_LINK_DOWN;
        end else begin
            it.command       = CMD_READING;
            it.packet_length = ($urandom_range(99) < 12) ? 8'($urandom_range(4)) :
                                                          8'($urandom_range(255, 5));
            case ($urandom_range(2))
                0:       it.spo2 = target;
                1:       it.spo2 = target + 8'($urandom_range(6)) - 8'd3;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic run_random_phase(input t_cfg c, input int n,
                                    input int unsigned tick_pct);
        write_settings(c);
        repeat (n) begin
            commands_pending.push_back(random_command(tick_pct, c.target_level));
            n_sent++;
        end
    endtask

    // main sequence
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_TARGET_LEVEL;
        i_cfg_data           = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_TICK;
        cmd_if.packet_length = '0;
        cmd_if.spo2          = '0;
        cmd_if.heart_rate    = '0;
        res_if.ready         = 1'b0;

        cfg_shadow = '{target_level: RST_TARGET_LEVEL, move_chunk: RST_MOVE_CHUNK,
                       valve_limit: RST_VALVE_LIMIT, half_period: RST_HALF_PERIOD,
                       silence_limit: RST_SILENCE_LIMIT};
        pos_q     = '0;
        pend_q    = '0;
        phase_q   = '0;
        silence_q = '0;
        dir_q     = 1'b0;
        level_q   = 1'b0;
        linked_q  = 1'b0;
        alarm_q   = 1'b0;
        spo2_q    = '0;
        pulse_q   = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short packet, open, drop mid-move, link during move, alarm
        write_settings('{target_level: 8'd98, move_chunk: 10'd3, valve_limit: 10'd4,
                         half_period: 16'd1, silence_limit: 32'd3});
        queue_command(CMD_READING, 4, 50, 60);
        queue_command(CMD_READING, 5, 90, 255);
        queue_command(CMD_READING, 255, 90, 70);
        queue_command(CMD_LINK_UP, 0, 0, 0);
        repeat (6) queue_command(CMD_TICK, 0, 0, 0);
        queue_command(CMD_LINK_DOWN, 255, 255, 255);
        // open against the valve limit, then nothing left to open
        queue_command(CMD_READING, 5, 0, 0);
        repeat (2) queue_command(CMD_TICK, 0, 0, 0);
        queue_command(CMD_READING, 200, 97, 80);
        queue_command(CMD_READING, 5, 98, 80);
        // close, then change timing mid-move
        queue_command(CMD_READING, 5, 255, 255);
        repeat (2) queue_command(CMD_TICK, 0, 0, 0);

        // directed: zero chunk, zero half period, widest limits
        write_settings('{target_level: 8'd255, move_chunk: 10'd0, valve_limit: 10'd1023,
                         half_period: 16'd0, silence_limit: 32'hFFFF_FFFF});
        repeat (4) queue_command(CMD_TICK, 0, 0, 0);
        queue_command(CMD_READING, 5, 0, 0);
        queue_command(CMD_LINK_UP, 0, 0, 0);
        queue_command(CMD_TICK, 0, 0, 0);

        // random phases over several settings
        run_random_phase('{target_level: 8'd98, move_chunk: 10'd4, valve_limit: 10'd20,
                           half_period: 16'd1, silence_limit: 32'd8}, 250, 70);
        run_random_phase('{target_level: 8'd255, move_chunk: 10'd1023, valve_limit: 10'd30,
                           half_period: 16'd0, silence_limit: 32'hFFFF_FFFF}, 200, 80);
        run_random_phase('{target_level: 8'd0, move_chunk: 10'd1, valve_limit: 10'd0,
                           half_period: 16'd2, silence_limit: 32'd1}, 200, 70);
        run_random_phase('{target_level: 8'd100, move_chunk: 10'd7, valve_limit: 10'd1023,
                           half_period: 16'd3, silence_limit: 32'd40}, 450, 75);
        run_random_phase('{target_level: RST_TARGET_LEVEL, move_chunk: RST_MOVE_CHUNK,
                           valve_limit: RST_VALVE_LIMIT, half_period: 16'd65535,
                           silence_limit: RST_SILENCE_LIMIT}, 150, 80);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d command transactions over %0d register settings: %0d moves, %0d steps",
                 n_taken, n_settings, n_moves, n_steps);
        $display("%0d readings dropped during moves, alarm raised %0d times",
                 n_dropped, n_alarms);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ oxygen_valve_stepper_control_top.f @@
+incdir+rtl
rtl/ovsc_pkg.sv
rtl/ovsc_channels.sv
rtl/ovsc_cfg_regs.sv
rtl/ovsc_core.sv
rtl/oxygen_valve_stepper_control_top.sv
rtl/ovsc_checker.sv
dv/oxygen_valve_stepper_control_top_test.sv
